// ===== rtl/gnpm_pkg.sv =====
// shared types and constants of the greedy nearest point matcher
`default_nettype none

package gnpm_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int IN_W           = 16;
  localparam int ROW_W          = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PERM_RD,
    ST_MOV_RD,
    ST_DIFF,
    ST_SQ,
    ST_CMP,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT
  } state_t;

  // control of the shared distance unit
  typedef struct packed {
    logic       load;
    logic       sq;
    logic [1:0] axis;
  } dist_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/gnpm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module gnpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/gnpm_dist.sv =====
// shared squared distance unit: one multiplier, one axis per cycle
`default_nettype none

module gnpm_dist
  import gnpm_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire dist_ctl_t                   ctl,
  input  wire logic [3*COORD_BITS-1:0]     tgt,
  input  wire logic [3*COORD_BITS-1:0]     mov,
  output logic      [2*COORD_BITS+3:0]     sq_sum
);

  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int SUM_W = PW + 2;

  logic signed [DW-1:0]    diff_r [3];
  logic        [PW-1:0]    prod_r;
  logic        [SUM_W-1:0] acc_r;
  logic signed [DW-1:0]    dsel;
  logic signed [PW-1:0]    sq;

  always_comb begin
    case (ctl.axis)
      2'd0:    dsel = diff_r[0];
      2'd1:    dsel = diff_r[1];
      2'd2:    dsel = diff_r[2];
      default: dsel = diff_r[0];
    endcase
  end

  assign sq     = dsel * dsel;
  assign sq_sum = acc_r + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int c = 0; c < 3; c++) begin
        diff_r[c] <= $signed({tgt[c*COORD_BITS + COORD_BITS-1],
                              tgt[c*COORD_BITS +: COORD_BITS]})
                   - $signed({mov[c*COORD_BITS + COORD_BITS-1],
                              mov[c*COORD_BITS +: COORD_BITS]});
      end
    end
    if (ctl.sq) begin
      prod_r <= $unsigned(sq);
      // first axis drops the stale product of the previous candidate
      acc_r  <= (ctl.axis == 2'd0) ? '0 : acc_r + SUM_W'(prod_r);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/greedy_nearest_point_matcher.sv =====
// top level: pair loading, permutation scan sequencer and result register
// a set of n pairs emits row t after a scan of the n-t candidates left for that row,
// paced by one shared multiplier, three axes per candidate
// throughput: one pair per cycle while loading; no request is taken during a match
// each candidate passes through permutation read, moving point read, difference, 3 squares, compare
// reset: synchronous active low, clears sequencer, pair count, permutation valid bits, output valid
`default_nettype none

module greedy_nearest_point_matcher
  import gnpm_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [IN_W-1:0]  in_target_x,
  input  wire logic signed [IN_W-1:0]  in_target_y,
  input  wire logic signed [IN_W-1:0]  in_target_z,
  input  wire logic signed [IN_W-1:0]  in_moving_x,
  input  wire logic signed [IN_W-1:0]  in_moving_y,
  input  wire logic signed [IN_W-1:0]  in_moving_z,
  input  wire logic                    in_last_pair,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [ROW_W-1:0]             out_target_row,
  output logic [ROW_W-1:0]             out_moving_row,
  output logic                         out_last_result
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int PT_W  = 3 * COORD_BITS;
  localparam int SUM_W = 2 * (COORD_BITS + 1) + 2;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] cnt_r, last_idx_r, t_r, p_r, m_r;
  logic [IDX_W-1:0] best_pos_r, best_m_r, perm_t_r;
  logic [SUM_W-1:0] best_r;
  logic [1:0]       axis_r;
  logic [MAX_POINTS-1:0] valid_r;
  logic             perm_vld_r;
  logic [IDX_W-1:0] perm_addr_r;

  logic             out_valid_r, out_last_r;
  logic [ROW_W-1:0] out_trow_r, out_mrow_r;

  logic [IN_W-1:0] raw_t [3];
  logic [IN_W-1:0] raw_m [3];
  logic [PT_W-1:0] tgt_wdata, mov_wdata, tgt_q, mov_q;
  logic [IDX_W-1:0] perm_q, perm_val, perm_waddr, perm_wdata;
  logic            perm_we, pt_we, in_fire, set_end, emit_fire;
  logic [SUM_W-1:0] sq_sum;
  dist_ctl_t       dctl;

  assign raw_t[0] = in_target_x;
  assign raw_t[1] = in_target_y;
  assign raw_t[2] = in_target_z;
  assign raw_m[0] = in_moving_x;
  assign raw_m[1] = in_moving_y;
  assign raw_m[2] = in_moving_z;

  // low coordinate bits kept; above the port width they read as zero
  for (genvar c = 0; c < 3; c++) begin : g_axis
    for (genvar i = 0; i < COORD_BITS; i++) begin : g_bit
      if (i < IN_W) begin : g_in
        assign tgt_wdata[c*COORD_BITS + i] = raw_t[c][i];
        assign mov_wdata[c*COORD_BITS + i] = raw_m[c][i];
      end else begin : g_zero
        assign tgt_wdata[c*COORD_BITS + i] = 1'b0;
        assign mov_wdata[c*COORD_BITS + i] = 1'b0;
      end
    end
  end

  assign in_fire   = in_valid && in_ready;
  assign set_end   = in_last_pair || (cnt_r == IDX_W'(MAX_POINTS - 1));
  assign emit_fire = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // entries not yet swapped in this set hold their own index
  assign perm_val = perm_vld_r ? perm_q : perm_addr_r;

  gnpm_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_tgt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (cnt_r),
    .wdata (tgt_wdata),
    .raddr (t_r),
    .rdata (tgt_q)
  );

  gnpm_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_mov_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (cnt_r),
    .wdata (mov_wdata),
    .raddr (perm_val),
    .rdata (mov_q)
  );

  gnpm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_perm_ram (
    .clk   (clk),
    .we    (perm_we),
    .waddr (perm_waddr),
    .wdata (perm_wdata),
    .raddr (p_r),
    .rdata (perm_q)
  );

  gnpm_dist #(.COORD_BITS(COORD_BITS)) u_dist (
    .clk    (clk),
    .ctl    (dctl),
    .tgt    (tgt_q),
    .mov    (mov_q),
    .sq_sum (sq_sum)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_fire && set_end) state_nxt = ST_PERM_RD;
      ST_PERM_RD: state_nxt = ST_MOV_RD;
      ST_MOV_RD:  state_nxt = ST_DIFF;
      ST_DIFF:    state_nxt = ST_SQ;
      ST_SQ:      if (axis_r == 2'd2) state_nxt = ST_CMP;
      ST_CMP:     state_nxt = (p_r == last_idx_r) ? ST_SWAP_A : ST_PERM_RD;
      ST_SWAP_A:  state_nxt = ST_SWAP_B;
      ST_SWAP_B:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_fire) state_nxt = (t_r == last_idx_r) ? ST_IDLE : ST_PERM_RD;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    pt_we      = 1'b0;
    perm_we    = 1'b0;
    perm_waddr = t_r;
    perm_wdata = best_m_r;
    dctl       = '{load: 1'b0, sq: 1'b0, axis: axis_r};
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        pt_we    = in_valid;
      end
      ST_DIFF: dctl.load = 1'b1;
      ST_SQ:   dctl.sq   = 1'b1;
      ST_SWAP_A: begin
        perm_we    = 1'b1;
        perm_waddr = best_pos_r;
        perm_wdata = perm_t_r;
      end
      ST_SWAP_B: perm_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        cnt_r <= set_end ? '0 : cnt_r + 1'b1;
        if (set_end) begin
          valid_r <= '0;
        end
      end
      if (perm_we) begin
        valid_r[perm_waddr] <= 1'b1;
      end
      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    perm_vld_r  <= valid_r[p_r];
    perm_addr_r <= p_r;
    if (in_fire && set_end) begin
      last_idx_r <= cnt_r;
      t_r        <= '0;
      p_r        <= '0;
    end
    if (state_r == ST_MOV_RD) begin
      m_r <= perm_val;
    end
    if (state_r == ST_DIFF) begin
      axis_r <= 2'd0;
    end
    if (state_r == ST_SQ) begin
      axis_r <= axis_r + 2'd1;
    end
    if (state_r == ST_CMP) begin
      // the first candidate of a row always seeds the best, ties keep the earlier one
      if (p_r == t_r || sq_sum < best_r) begin
        best_r     <= sq_sum;
        best_pos_r <= p_r;
        best_m_r   <= m_r;
      end
      if (p_r == t_r) begin
        perm_t_r <= m_r;
      end
      if (p_r != last_idx_r) begin
        p_r <= p_r + 1'b1;
      end
    end
    if (emit_fire) begin
      out_trow_r <= ROW_W'(t_r);
      out_mrow_r <= ROW_W'(best_m_r);
      out_last_r <= (t_r == last_idx_r);
      t_r        <= t_r + 1'b1;
      p_r        <= t_r + 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_target_row  = out_trow_r;
  assign out_moving_row  = out_mrow_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire
